// ----- rtl/core/fpf_pkg.sv -----
// Shared constants, types and field offsets for the fog parameter fader.
package fpf_pkg;

   localparam int COLOUR_W  = 32;
   localparam int DIST_W    = 24;
   localparam int DENS_W    = 16;
   localparam int TIME_W    = 24;
   localparam int FRAC_W    = 16;
   localparam int LANE_W    = DIST_W + 2;
   localparam int PROD_W    = DIST_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(FRAC_W);

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 104;

   // request tdata offsets
   localparam int RQ_FADE_ON = 0;
   localparam int RQ_COLOUR  = 1;
   localparam int RQ_NEAR    = 33;
   localparam int RQ_FAR     = 57;
   localparam int RQ_DENS    = 81;
   localparam int RQ_FTIME   = 97;
   localparam int RQ_ELAPSED = 121;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   localparam logic [COLOUR_W-1:0] RST_COLOUR  = 32'hff80_8080;
   localparam logic [DIST_W-1:0]   RST_NEAR    = 24'd25600;
   localparam logic [DIST_W-1:0]   RST_FAR     = 24'd256000;
   localparam logic [DENS_W-1:0]   RST_DENSITY = 16'd200;

   typedef logic [2:0] lane_type;
   localparam lane_type LANE_C0      = 3'd0;
   localparam lane_type LANE_C1      = 3'd1;
   localparam lane_type LANE_C2      = 3'd2;
   localparam lane_type LANE_C3      = 3'd3;
   localparam lane_type LANE_NEAR    = 3'd4;
   localparam lane_type LANE_FAR     = 3'd5;
   localparam lane_type LANE_DENSITY = 3'd6;
   localparam lane_type LANE_LAST    = LANE_DENSITY;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/core/fpf_div.sv -----
// Radix-2 restoring divider producing the Q0.16 fade fraction elapsed / time_left.
module fpf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fpf_pkg::TIME_W-1:0]     dividend,
   input  logic [fpf_pkg::TIME_W-1:0]     divisor,
   output fpf_pkg::div_status_type        status,
   output logic [fpf_pkg::FRAC_W-1:0]     quotient
);
   import fpf_pkg::*;

   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W-1:0]    dvs_ff, dvs_in;
   logic [FRAC_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TIME_W:0]      rem2;
   logic [TIME_W:0]      sub;
   logic                 ge;

   // dividend < divisor on entry, so the remainder stays below the divisor
   assign rem2 = {rem_ff, 1'b0};
   assign sub  = rem2 - {1'b0, dvs_ff};
   assign ge   = rem2 >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dvs_in  = divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? sub[TIME_W-1:0] : rem2[TIME_W-1:0];
         quo_in = {quo_ff[FRAC_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- rtl/core/fpf_scale.sv -----
// Shared multiply unit: cur + trunc((goal - cur) * k / 65536), one lane per issue.
module fpf_scale (
   input  logic                                clock,
   input  logic                                issue,
   input  logic signed [fpf_pkg::LANE_W-1:0]   cur_val,
   input  logic signed [fpf_pkg::LANE_W-1:0]   goal_val,
   input  logic [fpf_pkg::FRAC_W-1:0]          frac,
   output logic signed [fpf_pkg::LANE_W-1:0]   result
);
   import fpf_pkg::*;

   logic signed [LANE_W-1:0] diff;
   logic signed [LANE_W-1:0] diff_neg;
   logic [DIST_W-1:0]        mag;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [LANE_W-1:0] base_ff, base_in;
   logic                     neg_ff, neg_in;
   logic signed [LANE_W-1:0] step;

   assign diff     = goal_val - cur_val;
   assign diff_neg = -diff;
   assign mag      = diff[LANE_W-1] ? diff_neg[DIST_W-1:0] : diff[DIST_W-1:0];

   always_comb begin
      prod_in = prod_ff;
      base_in = base_ff;
      neg_in  = neg_ff;
      if (issue) begin
         prod_in = PROD_W'(mag) * PROD_W'(frac);
         base_in = cur_val;
         neg_in  = diff[LANE_W-1];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
      neg_ff  <= neg_in;
   end

   assign step   = $signed({2'b00, prod_ff[PROD_W-1:FRAC_W]});
   assign result = neg_ff ? base_ff - step : base_ff + step;

endmodule

// ----- rtl/core/fog_parameter_fade.sv -----
// Fog parameter fader top level: request decode, lane sequencer and fog state.
//
// Requests arrive on req_* (tuser = op: 0 tick, 1 set); every request gives one
// response on rsp_* holding the fog values after the update plus the fading flag.
// A set request, an idle tick or a tick that ends the fade is handled in the
// accept cycle; the sequencer then passes through ST_DONE, which loads the
// response register, and returns to idle before it takes the next request.
// A tick inside a fade runs a restoring divide for k = elapsed/time_left in ST_DIV,
// which waits for the divide, then seven lanes (four colour bytes, near, far,
// density) through one shared 24x16 multiplier, each lane passing through ST_MUL
// and ST_UPD, and then ST_DONE to load the output.
// The divider yields one quotient bit per cycle; one multiplier serves all lanes.
// req_tready is high only while the sequencer is idle; a new request may be taken
// while the previous response is still waiting in the output register.
// If the receiver stalls, the next response waits in the sequencer until the output
// register empties. Reset clears the handshake and loads the default fog setting
// (ARGB ff808080, near 100.0, far 1000.0, density 200) with no fade running.
module fog_parameter_fade (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fade_on, new_colour, new_near, new_far, new_density, fade_time, elapsed, pad
   input  logic [fpf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // fog_colour, fog_near, fog_far, fog_density, fading, pad
   output logic [fpf_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import fpf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   lane_type              lane_ff, lane_in;
   logic [COLOUR_W-1:0]   cur_colour_ff, cur_colour_in, goal_colour_ff, goal_colour_in;
   logic [DIST_W-1:0]     cur_near_ff, cur_near_in, goal_near_ff, goal_near_in;
   logic [DIST_W-1:0]     cur_far_ff, cur_far_in, goal_far_ff, goal_far_in;
   logic [DENS_W-1:0]     cur_dens_ff, cur_dens_in, goal_dens_ff, goal_dens_in;
   logic [TIME_W-1:0]     time_left_ff, time_left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  in_fade_on;
   logic [COLOUR_W-1:0]   in_colour;
   logic [DIST_W-1:0]     in_near, in_far;
   logic [DENS_W-1:0]     in_dens;
   logic [TIME_W-1:0]     in_ftime, in_elapsed;
   logic                  div_start;
   div_status_type        div_status;
   logic [FRAC_W-1:0]     frac;
   logic signed [LANE_W-1:0] lane_cur, lane_goal, lane_res;

   assign in_fade_on = req_tdata[RQ_FADE_ON];
   assign in_colour  = req_tdata[RQ_COLOUR +: COLOUR_W];
   assign in_near    = req_tdata[RQ_NEAR +: DIST_W];
   assign in_far     = req_tdata[RQ_FAR +: DIST_W];
   assign in_dens    = req_tdata[RQ_DENS +: DENS_W];
   assign in_ftime   = req_tdata[RQ_FTIME +: TIME_W];
   assign in_elapsed = req_tdata[RQ_ELAPSED +: TIME_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign div_start  = accept && (req_tuser == OP_TICK) && (time_left_ff != '0)
                       && (in_elapsed < time_left_ff);

   fpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (in_elapsed),
      .divisor  (time_left_ff),
      .status   (div_status),
      .quotient (frac)
   );

   always_comb begin
      unique case (lane_ff)
         LANE_C0: begin
            lane_cur  = $signed({18'd0, cur_colour_ff[7:0]});
            lane_goal = $signed({18'd0, goal_colour_ff[7:0]});
         end
         LANE_C1: begin
            lane_cur  = $signed({18'd0, cur_colour_ff[15:8]});
            lane_goal = $signed({18'd0, goal_colour_ff[15:8]});
         end
         LANE_C2: begin
            lane_cur  = $signed({18'd0, cur_colour_ff[23:16]});
            lane_goal = $signed({18'd0, goal_colour_ff[23:16]});
         end
         LANE_C3: begin
            lane_cur  = $signed({18'd0, cur_colour_ff[31:24]});
            lane_goal = $signed({18'd0, goal_colour_ff[31:24]});
         end
         LANE_NEAR: begin
            lane_cur  = $signed({2'd0, cur_near_ff});
            lane_goal = $signed({2'd0, goal_near_ff});
         end
         LANE_FAR: begin
            lane_cur  = $signed({2'd0, cur_far_ff});
            lane_goal = $signed({2'd0, goal_far_ff});
         end
         default: begin
            lane_cur  = $signed({{(LANE_W-DENS_W){cur_dens_ff[DENS_W-1]}}, cur_dens_ff});
            lane_goal = $signed({{(LANE_W-DENS_W){goal_dens_ff[DENS_W-1]}}, goal_dens_ff});
         end
      endcase
   end

   fpf_scale u_scale (
      .clock    (clock),
      .issue    (state_ff == ST_MUL),
      .cur_val  (lane_cur),
      .goal_val (lane_goal),
      .frac     (frac),
      .result   (lane_res)
   );

   always_comb begin
      state_in       = state_ff;
      lane_in        = lane_ff;
      cur_colour_in  = cur_colour_ff;
      cur_near_in    = cur_near_ff;
      cur_far_in     = cur_far_ff;
      cur_dens_in    = cur_dens_ff;
      goal_colour_in = goal_colour_ff;
      goal_near_in   = goal_near_ff;
      goal_far_in    = goal_far_ff;
      goal_dens_in   = goal_dens_ff;
      time_left_in   = time_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
               if (req_tuser == OP_SET) begin
                  if (in_fade_on && (in_ftime != '0)) begin
                     goal_colour_in = in_colour;
                     goal_near_in   = in_near;
                     goal_far_in    = in_far;
                     goal_dens_in   = in_dens;
                     time_left_in   = in_ftime;
                  end else begin
                     cur_colour_in = in_colour;
                     cur_near_in   = in_near;
                     cur_far_in    = in_far;
                     cur_dens_in   = in_dens;
                     time_left_in  = '0;
                  end
               end else if (time_left_ff != '0) begin
                  if (div_start) begin
                     time_left_in = time_left_ff - in_elapsed;
                     lane_in      = LANE_C0;
                     state_in     = ST_DIV;
                  end else begin
                     cur_colour_in = goal_colour_ff;
                     cur_near_in   = goal_near_ff;
                     cur_far_in    = goal_far_ff;
                     cur_dens_in   = goal_dens_ff;
                     time_left_in  = '0;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            unique case (lane_ff)
               LANE_C0:   cur_colour_in[7:0]   = lane_res[7:0];
               LANE_C1:   cur_colour_in[15:8]  = lane_res[7:0];
               LANE_C2:   cur_colour_in[23:16] = lane_res[7:0];
               LANE_C3:   cur_colour_in[31:24] = lane_res[7:0];
               LANE_NEAR: cur_near_in          = lane_res[DIST_W-1:0];
               LANE_FAR:  cur_far_in           = lane_res[DIST_W-1:0];
               default:   cur_dens_in          = lane_res[DENS_W-1:0];
            endcase
            if (lane_ff == LANE_LAST) begin
               state_in = ST_DONE;
            end else begin
               lane_in  = lane_ff + lane_type'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, (time_left_ff != '0), cur_dens_ff, cur_far_ff,
                               cur_near_ff, cur_colour_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         lane_ff        <= LANE_C0;
         cur_colour_ff  <= RST_COLOUR;
         cur_near_ff    <= RST_NEAR;
         cur_far_ff     <= RST_FAR;
         cur_dens_ff    <= RST_DENSITY;
         goal_colour_ff <= RST_COLOUR;
         goal_near_ff   <= RST_NEAR;
         goal_far_ff    <= RST_FAR;
         goal_dens_ff   <= RST_DENSITY;
         time_left_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lane_ff        <= lane_in;
         cur_colour_ff  <= cur_colour_in;
         cur_near_ff    <= cur_near_in;
         cur_far_ff     <= cur_far_in;
         cur_dens_ff    <= cur_dens_in;
         goal_colour_ff <= goal_colour_in;
         goal_near_ff   <= goal_near_in;
         goal_far_ff    <= goal_far_in;
         goal_dens_ff   <= goal_dens_in;
         time_left_ff   <= time_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_only_in_fade: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (time_left_ff != '0))
      else $error("divide running with no fade time left");

   a_lane_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_UPD) |-> (lane_ff <= LANE_LAST))
      else $error("lane index out of range");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == ST_DIV && div_status.busy))
      else $error("divider not running after start");

   a_goal_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> $stable(goal_colour_ff) && $stable(time_left_ff))
      else $error("goal or time changed during lane update");

endmodule
